FILE: sv/bsmt_pkg.sv
`timescale 1ns / 1ps

package bsmt_pkg;

    // default sizes of the table
    localparam int DEF_NUM_STORES = 16;
    localparam int DEF_NUM_PROCS  = 64;
    localparam int DEF_PAGE_SHIFT = 12;
    localparam int DEF_MAX_PAGES  = 256;

    // field widths of one input item
    localparam int OP_W     = 3;
    localparam int PID_W    = 6;
    localparam int VADDR_W  = 32;
    localparam int VPAGE_W  = 20;
    localparam int SIDX_W   = 4;
    localparam int COUNT_W  = 9;

    // field widths of one result item
    localparam int STORE_W  = 4;
    localparam int OFFSET_W = 8;

    // bit positions inside s_tdata, lowest field first
    localparam int OP_LSB    = 0;
    localparam int PID_LSB   = OP_LSB + OP_W;
    localparam int VADDR_LSB = PID_LSB + PID_W;
    localparam int VPAGE_LSB = VADDR_LSB + VADDR_W;
    localparam int SIDX_LSB  = VPAGE_LSB + VPAGE_W;
    localparam int COUNT_LSB = SIDX_LSB + SIDX_W;
    localparam int S_TDATA_W = 80;

    // bit positions inside m_tdata
    localparam int OK_LSB     = 0;
    localparam int STORE_LSB  = 1;
    localparam int OFFSET_LSB = STORE_LSB + STORE_W;
    localparam int M_TDATA_W  = 16;

    // share count limit
    localparam int SHARE_W = 7;
    localparam logic [SHARE_W-1:0] SHARE_MAX = 7'd127;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_MAP    = 3'd1,
        OP_UNMAP  = 3'd2,
        OP_FREE   = 3'd3,
        OP_ALLOC  = 3'd4
    } op_t;

    // one mapping of a process onto a store
    typedef struct packed {
        logic               valid;
        logic [VPAGE_W-1:0] start;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SHARE_RD,
        ST_UPDATE,
        ST_ALLOC,
        ST_DONE
    } state_t;

endpackage

FILE: sv/backing_store_map_table_core.sv
`timescale 1ns / 1ps

// Backing store map table. Each item on s_ carries one operation (lookup, map, unmap,
// free store, allocate store) and gives exactly one result item on m_. The per-process
// entries live in a single-port-read memory and one range comparator walks a process's
// entries one store per cycle, so the cost of an item is set by that walk: map reads the
// share count and then writes the entry, free updates its store directly, lookup scans
// from store 0 until a store hits or the last store misses, unmap scans like lookup and
// on a hit goes on to clear the entry and update the share count, allocate walks to the
// first free store. s_tready is high only while the sequencer is idle; a finished result
// waits in the output register. After reset the block clears the entry memory, all
// NUM_PROCS * NUM_STORES entries (1024 by default), before it takes an item.
module backing_store_map_table_core
    import bsmt_pkg::*;
#(
    parameter int NUM_STORES = DEF_NUM_STORES,
    parameter int NUM_PROCS  = DEF_NUM_PROCS,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT,
    parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // op[2:0], pid[8:3], vaddr[40:9], vpage[60:41], store_index[64:61],
    // page_count[73:65], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // ok[0], store_found[4:1], page_offset[12:5], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int DEPTH  = NUM_PROCS * NUM_STORES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(NUM_STORES);
    localparam int PG_W   = (VADDR_W - PAGE_SHIFT > VPAGE_W) ? VADDR_W - PAGE_SHIFT : VPAGE_W;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(NUM_STORES - 1);

    state_t state_reg, state_next;

    // latched item
    op_t                op_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [PG_W-1:0]    page_reg;
    logic [VPAGE_W-1:0] vpage_reg;
    logic [SIDX_W-1:0]  sidx_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_sat;

    // sequencer registers
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic                ok_reg, ok_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [NUM_STORES-1:0] in_use_reg, in_use_next;

    // output register
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // memory ports
    logic              ent_we;
    logic [ADDR_W-1:0] ent_waddr, ent_raddr;
    entry_t            ent_wdata, ent_rd;
    logic [$bits(entry_t)-1:0] ent_rdata;
    logic               sc_we;
    logic [IDX_W-1:0]   sc_waddr;
    logic [SHARE_W-1:0] sc_wdata, sc_rdata;

    logic                in_acc;
    logic                pid_ok, st_ok, idx_last, clr_in_range;
    logic [ADDR_W-1:0]   row_base;
    logic                cmp_hit;
    logic [OFFSET_W-1:0] cmp_off;

    assign in_acc       = s_tvalid && s_tready;
    assign pid_ok       = 32'(pid_reg) < 32'(NUM_PROCS);
    assign st_ok        = 32'(sidx_reg) < 32'(NUM_STORES);
    assign idx_last     = (idx_reg == IDX_LAST);
    assign clr_in_range = 32'(clr_reg) < 32'(NUM_STORES);
    assign row_base     = ADDR_W'(pid_reg) * ADDR_W'(NUM_STORES);
    assign ent_raddr    = row_base + ADDR_W'(idx_next);
    assign ent_rd       = entry_t'(ent_rdata);

    // page count saturates at the store size
    always_comb begin
        cnt_sat = s_tdata[COUNT_LSB +: COUNT_W];
        if (32'(s_tdata[COUNT_LSB +: COUNT_W]) > 32'(MAX_PAGES)) begin
            cnt_sat = COUNT_W'(MAX_PAGES);
        end
    end

    // per-process entry memory
    bsmt_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // share counts, one per store
    bsmt_ram #(
        .WIDTH (SHARE_W),
        .DEPTH (NUM_STORES)
    ) u_share_ram (
        .aclk  (aclk),
        .we    (sc_we),
        .waddr (sc_waddr),
        .wdata (sc_wdata),
        .raddr (idx_reg),
        .rdata (sc_rdata)
    );

    // shared range comparator
    bsmt_range_cmp #(
        .PG_W (PG_W)
    ) u_cmp (
        .entry_i  (ent_rd),
        .page_i   (page_reg),
        .hit_o    (cmp_hit),
        .offset_o (cmp_off)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (op_reg)
                    OP_LOOKUP, OP_UNMAP: state_next = pid_ok ? ST_SCAN_RD : ST_DONE;
                    OP_MAP:   state_next = (pid_ok && st_ok) ? ST_SHARE_RD : ST_DONE;
                    OP_FREE:  state_next = st_ok ? ST_UPDATE : ST_DONE;
                    OP_ALLOC: state_next = ST_ALLOC;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (cmp_hit) begin
                    state_next = (op_reg == OP_LOOKUP) ? ST_DONE : ST_SHARE_RD;
                end else if (idx_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHARE_RD: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = ST_DONE;
            end
            ST_ALLOC: begin
                if (!in_use_reg[idx_reg] || idx_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // datapath and memory controls
    always_comb begin
        idx_next      = idx_reg;
        clr_next      = clr_reg;
        ok_next       = ok_reg;
        off_next      = off_reg;
        in_use_next   = in_use_reg;
        ent_we        = 1'b0;
        ent_waddr     = row_base + ADDR_W'(idx_reg);
        ent_wdata     = '0;
        sc_we         = 1'b0;
        sc_waddr      = idx_reg;
        sc_wdata      = '0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            // clearing pass over both memories
            ST_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = clr_reg;
                sc_we     = clr_in_range;
                sc_waddr  = IDX_W'(clr_reg);
                clr_next  = clr_reg + 1'b1;
            end
            ST_DECODE: begin
                ok_next  = 1'b0;
                off_next = '0;
                idx_next = '0;
                if (op_reg inside {OP_MAP, OP_FREE}) begin
                    idx_next = IDX_W'(sidx_reg);
                end
            end
            // one store entry per cycle
            ST_SCAN: begin
                if (cmp_hit) begin
                    ok_next  = 1'b1;
                    off_next = cmp_off;
                end else if (!idx_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                ok_next = 1'b1;
                case (op_reg)
                    OP_MAP: begin
                        ent_we          = 1'b1;
                        ent_wdata.valid = 1'b1;
                        ent_wdata.start = vpage_reg;
                        ent_wdata.count = cnt_reg;
                        sc_we           = 1'b1;
                        sc_wdata        = (sc_rdata == SHARE_MAX) ? sc_rdata
                                                                  : sc_rdata + 1'b1;
                        in_use_next[idx_reg] = 1'b1;
                    end
                    OP_UNMAP: begin
                        ent_we   = 1'b1;
                        sc_we    = 1'b1;
                        sc_wdata = (sc_rdata == '0) ? sc_rdata : sc_rdata - 1'b1;
                    end
                    OP_FREE: begin
                        sc_we = 1'b1;
                        in_use_next[idx_reg] = 1'b0;
                    end
                    default: begin
                        ok_next = 1'b0;
                    end
                endcase
            end
            // first store not in use
            ST_ALLOC: begin
                if (!in_use_reg[idx_reg]) begin
                    ok_next = 1'b1;
                end else if (!idx_last) begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[OK_LSB] = ok_reg;
                    if (ok_reg) begin
                        m_tdata_next[STORE_LSB +: STORE_W]   = STORE_W'(idx_reg);
                        m_tdata_next[OFFSET_LSB +: OFFSET_W] = off_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            in_use_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            in_use_reg   <= in_use_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        off_reg     <= off_next;
        m_tdata_reg <= m_tdata_next;
        if (in_acc) begin
            op_reg    <= op_t'(s_tdata[OP_LSB +: OP_W]);
            pid_reg   <= s_tdata[PID_LSB +: PID_W];
            vpage_reg <= s_tdata[VPAGE_LSB +: VPAGE_W];
            sidx_reg  <= s_tdata[SIDX_LSB +: SIDX_W];
            cnt_reg   <= cnt_sat;
            if (op_t'(s_tdata[OP_LSB +: OP_W]) == OP_LOOKUP) begin
                page_reg <= PG_W'(s_tdata[VADDR_LSB +: VADDR_W] >> PAGE_SHIFT);
            end else begin
                page_reg <= PG_W'(s_tdata[VPAGE_LSB +: VPAGE_W]);
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: sv/bsmt_ram.sv
`timescale 1ns / 1ps

module bsmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/bsmt_range_cmp.sv
`timescale 1ns / 1ps

module bsmt_range_cmp
    import bsmt_pkg::*;
#(
    parameter int PG_W = 20
) (
    input  entry_t              entry_i,
    input  logic [PG_W-1:0]     page_i,
    output logic                hit_o,
    output logic [OFFSET_W-1:0] offset_o
);

    logic [PG_W-1:0] start_ext;
    logic [PG_W-1:0] diff;

    // page lies in [start, start + count) of a valid entry
    assign start_ext = PG_W'(entry_i.start);
    assign diff      = page_i - start_ext;
    assign hit_o     = entry_i.valid && (page_i >= start_ext)
                       && (diff < PG_W'(entry_i.count));
    assign offset_o  = diff[OFFSET_W-1:0];

endmodule

FILE: sv/bsmt_checker.sv
`timescale 1ns / 1ps

module bsmt_checker
    import bsmt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds its item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // a failed result carries no store and no offset
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[OK_LSB] |-> m_tdata[M_TDATA_W-1:STORE_LSB] == '0)
        else $error("failed result carries store or offset");

    // busy in the cycle after taking an item
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item taken while previous one still in work");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind backing_store_map_table_core bsmt_checker u_bsmt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
